### sv/deadline_budget_monitor_defines.svh
// Assertion macros shared by the deadline budget monitor RTL.
`ifndef DEADLINE_BUDGET_MONITOR_DEFINES_SVH
`define DEADLINE_BUDGET_MONITOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked only outside reset
`define DBM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define DBM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define DBM_ASSERT(lbl, prop, msg)

`define DBM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### sv/dbm_pkg.sv
`timescale 1ns / 1ps

package dbm_pkg;

   localparam int SLOTS = 16;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef logic [IDX_W-1:0] idx_type;

   localparam logic [2:0] OP_REGISTER     = 3'd0;
   localparam logic [2:0] OP_BEGIN        = 3'd1;
   localparam logic [2:0] OP_END          = 3'd2;
   localparam logic [2:0] OP_READ_MISSES  = 3'd3;
   localparam logic [2:0] OP_CLEAR_MISSES = 3'd4;
   localparam logic [2:0] OP_READ_BUDGET  = 3'd5;

   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_DUP_ID  = 2'd1;
   localparam logic [1:0] STS_FULL    = 2'd2;
   localparam logic [1:0] STS_NO_ID   = 2'd3;

   typedef struct packed {
      logic scan_start;
      logic scan_step;
      logic fetch;
      logic calc;
      logic write;
   } dbm_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic rsp_busy;
   } dbm_sts_type;

endpackage

### sv/deadline_budget_monitor.sv
`timescale 1ns / 1ps
// Deadline budget monitor: a table of SLOTS task slots (id, budget, start, miss count).
// Request channel req_*: one operation per item (op, task_id, budget, now_us),
// taken when req_valid is high and req_stall low. Response channel rsp_*: exactly
// one item per request (status, miss_total, budget_out), taken when rsp_valid is
// high and rsp_stall low.
// Each request walks the task-id store one slot a cycle to find the id and the
// lowest free slot, then reads the slot, compares the elapsed time and writes back.
// One request is in work at a time: req_stall stays high from acceptance through
// the write step, so a new item is taken only after the last one has been written.
// The slot walk over the single read port of the id store is the longest step.
// The finished result sits in an output register; the next request is accepted
// while it waits, and that request holds in its compare step while rsp_stall
// keeps the register occupied.
// Synchronous reset empties the table (all slots unused) and drops any pending
// result; slot contents need no clearing pass.
module deadline_budget_monitor import dbm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [2:0]   req_op,
   input  logic [15:0]  req_task_id,
   input  logic [31:0]  req_budget,
   input  logic [63:0]  req_now_us,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_status,
   output logic [31:0]  rsp_miss_total,
   output logic [31:0]  rsp_budget_out
);

   dbm_cmd_type cmd;
   dbm_sts_type sts;

   dbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dbm_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_op         (req_op),
      .req_task_id    (req_task_id),
      .req_budget     (req_budget),
      .req_now_us     (req_now_us),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_miss_total (rsp_miss_total),
      .rsp_budget_out (rsp_budget_out)
   );

endmodule

### sv/dbm_ctrl.sv
`timescale 1ns / 1ps
`include "deadline_budget_monitor_defines.svh"

module dbm_ctrl import dbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dbm_sts_type sts,
   output dbm_cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_SCAN     = 6'b000010,
      ST_SCAN_END = 6'b000100,
      ST_FETCH    = 6'b001000,
      ST_CALC     = 6'b010000,
      ST_WRITE    = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: state_in = ST_FETCH;
         ST_FETCH:    state_in = ST_CALC;
         ST_CALC: begin
            // hold until the result register can take the item
            if (!sts.rsp_busy) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE:    state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign cmd.scan_start = (state_ff == ST_IDLE) && req_valid;
   assign cmd.scan_step  = (state_ff == ST_SCAN);
   assign cmd.fetch      = (state_ff == ST_FETCH);
   assign cmd.calc       = (state_ff == ST_CALC);
   assign cmd.write      = (state_ff == ST_WRITE);

   `DBM_ASSERT_ALWAYS(a_reset_idle, reset |=> state_ff == ST_IDLE, "not idle after reset")
   `DBM_ASSERT(a_accept_scan, cmd.scan_start |=> state_ff == ST_SCAN, "accept did not start scan")
   `DBM_ASSERT(a_calc_hold, (state_ff == ST_CALC) && sts.rsp_busy |=> state_ff == ST_CALC, "left calc while result busy")

endmodule

### sv/dbm_dp.sv
`timescale 1ns / 1ps
`include "deadline_budget_monitor_defines.svh"

module dbm_dp import dbm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  dbm_cmd_type  cmd,
   output dbm_sts_type  sts,
   input  logic [2:0]   req_op,
   input  logic [15:0]  req_task_id,
   input  logic [31:0]  req_budget,
   input  logic [63:0]  req_now_us,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_status,
   output logic [31:0]  rsp_miss_total,
   output logic [31:0]  rsp_budget_out
);

   // slot stores, registered read
   logic [15:0] task_mem   [SLOTS];
   logic [31:0] limit_mem  [SLOTS];
   logic [63:0] start_mem  [SLOTS];
   logic [31:0] misses_mem [SLOTS];

   logic [SLOTS-1:0] used_ff, used_in;

   logic [2:0]  op_ff, op_in;
   logic [15:0] id_ff, id_in;
   logic [31:0] bud_ff, bud_in;
   logic [63:0] now_ff, now_in;

   idx_type scan_idx_ff, scan_idx_in;
   idx_type cmp_idx_ff, cmp_idx_in;
   logic    cmp_vld_ff, cmp_vld_in;
   logic    found_ff, found_in;
   idx_type hit_idx_ff, hit_idx_in;
   logic    free_ff, free_in;
   idx_type free_idx_ff, free_idx_in;

   logic [15:0] task_q_ff;
   logic [31:0] limit_q_ff;
   logic [63:0] start_q_ff;
   logic [31:0] misses_q_ff;

   logic over_ff, over_in;
   logic started_ff, started_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_miss_ff, rsp_miss_in;
   logic [31:0] rsp_bud_ff, rsp_bud_in;

   logic        cmp_used, cmp_hit;
   logic [63:0] elapsed;

   idx_type     wr_idx;
   logic        task_we, limit_we, start_we, miss_we, used_set;
   logic [63:0] start_wd;
   logic [31:0] miss_wd;
   logic [1:0]  status_c;
   logic [31:0] miss_c, bud_c;

   assign cmp_used = used_ff[cmp_idx_ff];
   assign cmp_hit  = cmp_vld_ff && cmp_used && (task_q_ff == id_ff);
   assign elapsed  = now_ff - start_q_ff;

   // scan control and request capture
   always_comb begin
      op_in       = op_ff;
      id_in       = id_ff;
      bud_in      = bud_ff;
      now_in      = now_ff;
      scan_idx_in = scan_idx_ff;
      cmp_idx_in  = cmp_idx_ff;
      cmp_vld_in  = cmd.scan_step;
      found_in    = found_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (cmd.scan_start) begin
         op_in       = req_op;
         id_in       = req_task_id;
         bud_in      = req_budget;
         now_in      = req_now_us;
         scan_idx_in = '0;
         cmp_vld_in  = 1'b0;
         found_in    = 1'b0;
         free_in     = 1'b0;
      end else begin
         if (cmd.scan_step) begin
            scan_idx_in = scan_idx_ff + IDX_W'(1);
            cmp_idx_in  = scan_idx_ff;
         end
         if (cmp_hit && !found_ff) begin
            found_in   = 1'b1;
            hit_idx_in = cmp_idx_ff;
         end
         // lowest free slot wins
         if (cmp_vld_ff && !cmp_used && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end
   end

   always_comb begin
      over_in    = over_ff;
      started_in = started_ff;
      if (cmd.calc) begin
         over_in    = elapsed > {32'd0, limit_q_ff};
         started_in = (start_q_ff != 64'd0);
      end
   end

   // operation decode, applied in the write step
   always_comb begin
      wr_idx   = (op_ff == OP_REGISTER) ? free_idx_ff : hit_idx_ff;
      task_we  = 1'b0;
      limit_we = 1'b0;
      start_we = 1'b0;
      miss_we  = 1'b0;
      used_set = 1'b0;
      start_wd = 64'd0;
      miss_wd  = 32'd0;
      status_c = STS_OK;
      miss_c   = 32'd0;
      bud_c    = 32'd0;
      unique case (op_ff) inside
         OP_REGISTER: begin
            if (found_ff) begin
               status_c = STS_DUP_ID;
            end else if (free_ff) begin
               task_we  = 1'b1;
               limit_we = 1'b1;
               start_we = 1'b1;
               miss_we  = 1'b1;
               used_set = 1'b1;
            end else begin
               status_c = STS_FULL;
            end
         end
         OP_BEGIN, OP_END, OP_READ_MISSES, OP_CLEAR_MISSES, OP_READ_BUDGET: begin
            if (!found_ff) begin
               status_c = STS_NO_ID;
            end else begin
               unique case (op_ff)
                  OP_BEGIN: begin
                     start_we = 1'b1;
                     start_wd = now_ff;
                  end
                  OP_END: begin
                     if (started_ff) begin
                        start_we = 1'b1;
                        miss_we  = over_ff;
                        miss_wd  = misses_q_ff + 32'd1;
                     end
                  end
                  OP_READ_MISSES:  miss_c  = misses_q_ff;
                  OP_CLEAR_MISSES: miss_we = 1'b1;
                  OP_READ_BUDGET:  bud_c   = limit_q_ff;
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      task_we  = task_we  && cmd.write;
      limit_we = limit_we && cmd.write;
      start_we = start_we && cmd.write;
      miss_we  = miss_we  && cmd.write;
      used_set = used_set && cmd.write;
   end

   always_comb begin
      used_in = used_ff;
      if (used_set) begin
         used_in[free_idx_ff] = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_miss_in   = rsp_miss_ff;
      rsp_bud_in    = rsp_bud_ff;
      if (cmd.write) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_c;
         rsp_miss_in   = miss_c;
         rsp_bud_in    = bud_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         cmp_vld_ff   <= cmp_vld_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      bud_ff        <= bud_in;
      now_ff        <= now_in;
      scan_idx_ff   <= scan_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      over_ff       <= over_in;
      started_ff    <= started_in;
      rsp_status_ff <= rsp_status_in;
      rsp_miss_ff   <= rsp_miss_in;
      rsp_bud_ff    <= rsp_bud_in;
   end

   always_ff @(posedge clock) begin
      if (task_we) begin
         task_mem[wr_idx] <= id_ff;
      end
      if (cmd.scan_step) begin
         task_q_ff <= task_mem[scan_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (limit_we) begin
         limit_mem[wr_idx] <= bud_ff;
      end
      if (cmd.fetch) begin
         limit_q_ff <= limit_mem[hit_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (start_we) begin
         start_mem[wr_idx] <= start_wd;
      end
      if (cmd.fetch) begin
         start_q_ff <= start_mem[hit_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (miss_we) begin
         misses_mem[wr_idx] <= miss_wd;
      end
      if (cmd.fetch) begin
         misses_q_ff <= misses_mem[hit_idx_ff];
      end
   end

   assign sts.scan_last = (scan_idx_ff == IDX_W'(SLOTS - 1));
   assign sts.rsp_busy  = rsp_valid_ff && rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_miss_total = rsp_miss_ff;
   assign rsp_budget_out = rsp_bud_ff;

   `DBM_ASSERT(a_write_free, cmd.write |-> !rsp_valid_ff, "result register still occupied")
   `DBM_ASSERT(a_hit_used, found_ff |-> used_ff[hit_idx_ff], "matched slot is not in use")
   `DBM_ASSERT(a_reg_unused, used_set |-> !used_ff[free_idx_ff], "register into a used slot")
   `DBM_ASSERT(a_rsp_source, $rose(rsp_valid_ff) |-> $past(cmd.write), "result without write step")

endmodule
